// ===== rtl/core/mmpw_pkg.sv =====
package mmpw_pkg;

  localparam int unsigned NumMotors  = 5;
  localparam int unsigned DutyW      = 8;
  localparam int unsigned TimeW      = 16;
  localparam int unsigned IdleW      = 17;
  localparam int unsigned DriveW     = 2;
  localparam int unsigned MotorIdxW  = 3;
  localparam int unsigned ProdW      = DutyW + TimeW;
  localparam int unsigned DivSteps   = DutyW;
  localparam int unsigned DivCntW    = $clog2(DivSteps);
  localparam int unsigned CfgIdxW    = 1;

  localparam int unsigned SDataW     = 16;
  localparam int unsigned SUserW     = 2;
  localparam int unsigned MDataW     = 56;

  localparam logic [TimeW-1:0] RampReset    = 16'd600;
  localparam logic [TimeW-1:0] TimeoutReset = 16'd400;
  localparam logic [IdleW-1:0] IdleMax      = {IdleW{1'b1}};
  localparam logic [TimeW-1:0] ElapsedMax   = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    ReqTick      = 2'd0,
    ReqStart     = 2'd1,
    ReqStopAll   = 2'd2,
    ReqKeepalive = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRampTime = 1'b0,
    CfgTimeout  = 1'b1
  } cfg_idx_e;

  localparam logic [DriveW-1:0] DriveOff = 2'd0;
  localparam logic [DriveW-1:0] DriveFwd = 2'd1;
  localparam logic [DriveW-1:0] DriveBwd = 2'd2;

  localparam logic [1:0] DirFwd = 2'b01;
  localparam logic [1:0] DirBwd = 2'b11;

  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] dividend;
    logic [TimeW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DutyW-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/mmpw_div.sv =====
module mmpw_div
  import mmpw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [TimeW-1:0]   rem_q, rem_d;
  logic [DutyW-1:0]   dvd_q, dvd_d;
  logic [TimeW-1:0]   dsr_q, dsr_d;
  logic [TimeW:0]     trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, dvd_q[DutyW-1]} - {1'b0, dsr_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.dividend[ProdW-1:DutyW];
      dvd_d  = req_i.dividend[DutyW-1:0];
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!trial[TimeW]) begin
        rem_d = trial[TimeW-1:0];
      end else begin
        rem_d = {rem_q[TimeW-2:0], dvd_q[DutyW-1]};
      end
      dvd_d = {dvd_q[DutyW-2:0], ~trial[TimeW]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

endmodule

// ===== rtl/core/multi_motor_pwm_ramp_watchdog.sv =====
// channel  | direction | fields
// s_axis   | in        | tuser: req_type; tdata: motor_sel, direction, target_speed
// m_axis   | out       | tdata: pwm_m1..pwm_m5, drive_m1..drive_m5, watchdog_trip
// cfg      | in        | cfg_idx_i 0 ramp_time, 1 idle_limit
//
// A command goes from StIdle to StDone; a tick also walks StRamp over each motor,
// and a ramping motor passes StDivStart and StDivWait (8-step shared divider).
// Reset clears all motor state and loads ramp_time 600, idle_limit 400.
// s_axis_tready is high only while no item is in work; a result stalled on
// m_axis holds the sequencer before its output register load.
module multi_motor_pwm_ramp_watchdog
  import mmpw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [SDataW-1:0]  s_axis_tdata,  // motor_sel, direction, target_speed
  input  logic [SUserW-1:0]  s_axis_tuser,  // req_type

  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [MDataW-1:0]  m_axis_tdata,  // pwm_m1..5, drive_m1..5, watchdog_trip

  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_wdata_i
);

  typedef enum logic [2:0] {
    StIdle,
    StRamp,
    StDivStart,
    StDivWait,
    StDone
  } state_e;

  state_e               state_q;
  logic [TimeW-1:0]     ramp_q, timeout_q;
  logic                 active_q [NumMotors];
  logic [DutyW-1:0]     target_q [NumMotors];
  logic [DutyW-1:0]     level_q  [NumMotors];
  logic [TimeW-1:0]     elapsed_q[NumMotors];
  logic [DriveW-1:0]    drive_q  [NumMotors];
  logic [IdleW-1:0]     idle_q;
  logic                 trip_q;
  logic [MotorIdxW-1:0] idx_q;
  logic [ProdW-1:0]     prod_q;
  logic                 m_valid_q;
  logic [MDataW-1:0]    m_data_q;

  req_e                 req;
  logic [MotorIdxW-1:0] sel;
  logic [MotorIdxW-1:0] sel_m;
  logic [1:0]           dir;
  logic [DutyW-1:0]     spd;
  logic [DriveW-1:0]    new_drive;
  logic [IdleW-1:0]     idle_inc;
  logic                 wd_fire;
  logic [TimeW-1:0]     el_new;
  logic [MDataW-1:0]    out_word;
  logic                 accept;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign req   = req_e'(s_axis_tuser);
  assign sel   = s_axis_tdata[2:0];
  assign dir   = s_axis_tdata[4:3];
  assign spd   = s_axis_tdata[12:5];
  assign sel_m = sel - 1'b1;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    unique case (dir)
      DirFwd:  new_drive = DriveFwd;
      DirBwd:  new_drive = DriveBwd;
      default: new_drive = DriveOff;
    endcase
  end

  assign idle_inc = (idle_q == IdleMax) ? idle_q : idle_q + 1'b1;
  assign wd_fire  = idle_inc > {1'b0, timeout_q};
  assign el_new   = (elapsed_q[idx_q] == ElapsedMax) ? elapsed_q[idx_q]
                                                     : elapsed_q[idx_q] + 1'b1;

  always_comb begin
    out_word = '0;
    for (int i = 0; i < NumMotors; i++) begin
      out_word[i*DutyW +: DutyW] = level_q[i];
      out_word[NumMotors*DutyW + i*DriveW +: DriveW] = drive_q[i];
    end
    out_word[NumMotors*(DutyW+DriveW)] = trip_q;
  end

  assign div_req.start    = (state_q == StDivStart);
  assign div_req.dividend = prod_q;
  assign div_req.divisor  = ramp_q;

  mmpw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_q    <= RampReset;
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgRampTime: ramp_q    <= cfg_wdata_i;
        CfgTimeout:  timeout_q <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      idle_q    <= '0;
      trip_q    <= 1'b0;
      idx_q     <= '0;
      prod_q    <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < NumMotors; i++) begin
        active_q[i]  <= 1'b0;
        target_q[i]  <= '0;
        level_q[i]   <= '0;
        elapsed_q[i] <= '0;
        drive_q[i]   <= DriveOff;
      end
    end else begin
      if (state_q == StDone && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            trip_q <= (req == ReqTick) && wd_fire;
            idx_q  <= '0;
            unique case (req)
              ReqTick: begin
                state_q <= StRamp;
                if (wd_fire) begin
                  idle_q <= '0;
                  for (int i = 0; i < NumMotors; i++) begin
                    active_q[i] <= 1'b0;
                    level_q[i]  <= '0;
                    drive_q[i]  <= DriveOff;
                  end
                end else begin
                  idle_q <= idle_inc;
                end
              end
              ReqStart: begin
                state_q <= StDone;
                idle_q  <= '0;
                if (sel >= MotorIdxW'(1) && sel <= MotorIdxW'(NumMotors)) begin
                  drive_q[sel_m] <= new_drive;
                  if (!active_q[sel_m]) begin
                    target_q[sel_m]  <= spd;
                    elapsed_q[sel_m] <= '0;
                    level_q[sel_m]   <= '0;
                    active_q[sel_m]  <= 1'b1;
                  end
                end
              end
              ReqStopAll: begin
                state_q <= StDone;
                idle_q  <= '0;
                for (int i = 0; i < NumMotors; i++) begin
                  active_q[i] <= 1'b0;
                  level_q[i]  <= '0;
                  drive_q[i]  <= DriveOff;
                end
              end
              default: begin
                state_q <= StDone;
                idle_q  <= '0;
              end
            endcase
          end
        end
        StRamp: begin
          if (active_q[idx_q]) begin
            elapsed_q[idx_q] <= el_new;
            prod_q <= {{TimeW{1'b0}}, target_q[idx_q]} * {{DutyW{1'b0}}, el_new};
          end
          if (active_q[idx_q] && el_new < ramp_q) begin
            state_q <= StDivStart;
          end else begin
            if (active_q[idx_q]) begin
              level_q[idx_q] <= target_q[idx_q];
            end
            if (idx_q == MotorIdxW'(NumMotors - 1)) begin
              state_q <= StDone;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        StDivStart: begin
          state_q <= StDivWait;
        end
        StDivWait: begin
          if (div_rsp.done) begin
            level_q[idx_q] <= div_rsp.quot;
            if (idx_q == MotorIdxW'(NumMotors - 1)) begin
              state_q <= StDone;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= StRamp;
            end
          end
        end
        StDone: begin
          if (!m_valid_q || m_axis_tready) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StDone && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= out_word;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== tb/sv/tb_multi_motor_pwm_ramp_watchdog.sv =====
`timescale 1ns / 100ps

module tb_multi_motor_pwm_ramp_watchdog
  import mmpw_pkg::*;
;

  localparam int unsigned CycleLimit = 8_000_000;
  localparam int unsigned HoldAfter  = 200;
  localparam int unsigned HoldCycles = 700;

  class motor_status_model;
    logic [TimeW-1:0]  ramp_len;
    logic [TimeW-1:0]  wd_limit;
    bit                active  [NumMotors];
    logic [DutyW-1:0]  target  [NumMotors];
    logic [DutyW-1:0]  level   [NumMotors];
    logic [TimeW-1:0]  elapsed [NumMotors];
    logic [DriveW-1:0] drive   [NumMotors];
    logic [IdleW-1:0]  idle;
    logic [MDataW-1:0] status_q[$];
    int unsigned       errors;

    function new();
      ramp_len = RampReset;
      wd_limit = TimeoutReset;
      idle     = '0;
      errors   = 0;
      for (int m = 0; m < NumMotors; m++) begin
        active[m]  = 1'b0;
        target[m]  = '0;
        level[m]   = '0;
        elapsed[m] = '0;
        drive[m]   = DriveOff;
      end
    endfunction

    function void set_regs(logic [TimeW-1:0] ramp, logic [TimeW-1:0] tmo);
      ramp_len = ramp;
      wd_limit = tmo;
    endfunction

    function void halt_all();
      for (int m = 0; m < NumMotors; m++) begin
        active[m] = 1'b0;
        level[m]  = '0;
        drive[m]  = DriveOff;
      end
    endfunction

    function void note_request(req_e req, logic [2:0] sel, logic [1:0] dir,
                               logic [DutyW-1:0] spd);
      logic              trip;
      int unsigned       m;
      longint unsigned   prod;
      logic [MDataW-1:0] word;
      trip = 1'b0;
      if (req == ReqTick) begin
        if (idle < IdleMax) idle++;
        if (idle > wd_limit) begin
          halt_all();
          idle = '0;
          trip = 1'b1;
        end
        for (int k = 0; k < NumMotors; k++) begin
          if (active[k]) begin
            if (elapsed[k] < ElapsedMax) elapsed[k]++;
            if (elapsed[k] >= ramp_len) begin
              level[k] = target[k];
            end else begin
              prod = longint'(target[k]) * longint'(elapsed[k]);
              level[k] = DutyW'(prod / longint'(ramp_len));
            end
          end
        end
      end else begin
        idle = '0;
        if (req == ReqStart && sel >= 1 && sel <= NumMotors) begin
          m = sel - 1;
          drive[m] = (dir == DirFwd) ? DriveFwd : (dir == DirBwd) ? DriveBwd : DriveOff;
          if (!active[m]) begin
            target[m]  = spd;
            elapsed[m] = '0;
            level[m]   = '0;
            active[m]  = 1'b1;
          end
        end else if (req == ReqStopAll) begin
          halt_all();
        end
      end
      word = '0;
      for (int k = 0; k < NumMotors; k++) begin
        word[k*DutyW +: DutyW] = level[k];
        word[NumMotors*DutyW + k*DriveW +: DriveW] = drive[k];
      end
      word[NumMotors*(DutyW+DriveW)] = trip;
      status_q.push_back(word);
    endfunction

    function void check_result(logic [MDataW-1:0] got);
      logic [MDataW-1:0] want;
      int unsigned       base;
      if (status_q.size() == 0) begin
        $error("status word with no expectation: %h", got);
        errors++;
        return;
      end
      want = status_q.pop_front();
      base = NumMotors * DutyW;
      for (int k = 0; k < NumMotors; k++) begin
        if (got[k*DutyW +: DutyW] !== want[k*DutyW +: DutyW]) begin
          $error("pwm_m%0d: expected %0d, got %0d", k + 1,
                 want[k*DutyW +: DutyW], got[k*DutyW +: DutyW]);
          errors++;
        end
        if (got[base + k*DriveW +: DriveW] !== want[base + k*DriveW +: DriveW]) begin
          $error("drive_m%0d: expected %0d, got %0d", k + 1,
                 want[base + k*DriveW +: DriveW], got[base + k*DriveW +: DriveW]);
          errors++;
        end
      end
      if (got[NumMotors*(DutyW+DriveW)] !== want[NumMotors*(DutyW+DriveW)]) begin
        $error("watchdog_trip: expected %0d, got %0d",
               want[NumMotors*(DutyW+DriveW)], got[NumMotors*(DutyW+DriveW)]);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [SDataW-1:0]  s_axis_tdata;   // motor_sel, direction, target_speed
  logic [SUserW-1:0]  s_axis_tuser;   // req_type
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [MDataW-1:0]  m_axis_tdata;   // pwm_m1..5, drive_m1..5, watchdog_trip
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [TimeW-1:0]   cfg_wdata_i;

  motor_status_model sb = new();
  int unsigned       cycle_cnt = 0;
  int unsigned       words_seen = 0;

  multi_motor_pwm_ramp_watchdog i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("multi_motor_pwm_ramp_watchdog test failed");
    $finish;
  end

  initial begin
    bit          held;
    int unsigned hold_left;
    int unsigned mode;
    held = 1'b0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        words_seen++;
      end
      if (!held && words_seen >= HoldAfter) begin
        held = 1'b1;
        hold_left = HoldCycles;
      end
      mode = (cycle_cnt / 97) % 4;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ((cycle_cnt % 5) == 0);
          default: m_axis_tready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  task automatic set_regs(logic [TimeW-1:0] ramp, logic [TimeW-1:0] tmo);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgRampTime;
    cfg_wdata_i <= ramp;
    @(posedge clk_i);
    cfg_idx_i   <= CfgTimeout;
    cfg_wdata_i <= tmo;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_regs(ramp, tmo);
  endtask

  task automatic push_cmd(req_e req, logic [2:0] sel, logic [1:0] dir,
                          logic [DutyW-1:0] spd);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= SDataW'({spd, dir, sel});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(req, sel, dir, spd);
  endtask

  task automatic drain_status();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.status_q.size() != 0);
  endtask

  task automatic run_random(int unsigned count, int unsigned tick_pct, bit gaps_on,
                            bit pause_mid);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned r;
    int unsigned k;
    bit          paused;
    req_e        req;
    logic [2:0]  sel;
    sent = 0;
    paused = 1'b0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && sent < count; i++) begin
        r = $urandom_range(0, 99);
        if (r < tick_pct) begin
          req = ReqTick;
        end else begin
          r = $urandom_range(0, 99);
          req = (r < 60) ? ReqStart : (r < 85) ? ReqKeepalive : ReqStopAll;
        end
        if ($urandom_range(0, 9) < 8) begin
          sel = 3'($urandom_range(1, NumMotors));
        end else begin
          k = $urandom_range(0, 2);
          sel = (k == 0) ? 3'd0 : 3'(NumMotors + k);
        end
        push_cmd(req, sel, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        sent++;
      end
      gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
      if (pause_mid && !paused && sent >= count / 2) begin
        paused = 1'b1;
        drain_status();
      end else if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ReqTick;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgRampTime;
    cfg_wdata_i   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_regs(16'd4, 16'd6);
    push_cmd(ReqTick, 3'd0, 2'b00, 8'd0);
    push_cmd(ReqStart, 3'd1, DirFwd, 8'd255);
    push_cmd(ReqStart, 3'd5, DirBwd, 8'd0);
    push_cmd(ReqStart, 3'd2, 2'b10, 8'd128);
    push_cmd(ReqStart, 3'd3, 2'b00, 8'd1);
    push_cmd(ReqStart, 3'd4, DirFwd, 8'd170);
    push_cmd(ReqStart, 3'd0, DirFwd, 8'd85);
    push_cmd(ReqStart, 3'd6, DirBwd, 8'd85);
    push_cmd(ReqStart, 3'd7, DirFwd, 8'd85);
    repeat (3) push_cmd(ReqTick, 3'd7, 2'b11, 8'd255);
    push_cmd(ReqStart, 3'd1, DirBwd, 8'd7);
    push_cmd(ReqKeepalive, 3'd0, 2'b00, 8'd0);
    repeat (2) push_cmd(ReqTick, 3'd0, 2'b00, 8'd0);
    push_cmd(ReqStopAll, 3'd0, 2'b00, 8'd0);
    push_cmd(ReqStart, 3'd1, DirFwd, 8'd200);
    repeat (8) push_cmd(ReqTick, 3'd0, 2'b00, 8'd0);
    drain_status();

    set_regs(16'd0, 16'hFFFF);
    push_cmd(ReqStart, 3'd2, DirFwd, 8'd99);
    repeat (2) push_cmd(ReqTick, 3'd0, 2'b00, 8'd0);
    drain_status();

    set_regs(RampReset, TimeoutReset);
    run_random(185, 60, 1'b1, 1'b1);
    drain_status();
    set_regs(16'd1, 16'd0);
    run_random(185, 50, 1'b0, 1'b0);
    drain_status();
    set_regs(16'd12, 16'd9);
    run_random(185, 85, 1'b1, 1'b0);
    drain_status();
    set_regs(16'hFFFF, 16'hFFFF);
    run_random(185, 60, 1'b1, 1'b0);
    drain_status();
    set_regs(16'($urandom_range(2, 64)), 16'($urandom_range(3, 40)));
    run_random(185, 75, 1'b1, 1'b0);
    drain_status();

    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.status_q.size() == 0) begin
      $display("multi_motor_pwm_ramp_watchdog test passed");
    end else begin
      $display("multi_motor_pwm_ramp_watchdog test failed");
    end
    $finish;
  end

endmodule
